@@ hw/rtl/apsp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the all-pairs shortest path block.
package apsp_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int ENTRIES   = MAX_NODES * MAX_NODES;
	localparam int ADDR_W    = 2 * NODE_W;

	// fixed field widths
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int WGT_W     = 16;
	localparam int DIST_W    = 24;
	localparam int ENTRY_W   = DIST_W + 1;
	localparam int IN_DATA_W = 24;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam logic [CNT_W-1:0] NODE_LIMIT = CNT_W'(MAX_NODES);

	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_EDGE  = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_READ  = 2'd3
	} apsp_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDATA,
		ST_LEG_RD,
		ST_LEG_WAIT,
		ST_COL,
		ST_FINISH,
		ST_RESP
	} apsp_state_t;

	typedef struct packed {
		logic                     reach;
		logic signed [DIST_W-1:0] path_len;
	} apsp_entry_t;

	// signed add clamped to the distance range
	function automatic logic signed [DIST_W-1:0] sat_add(
		input logic signed [DIST_W-1:0] x,
		input logic signed [DIST_W-1:0] y
	);
		logic signed [DIST_W:0] s;
		s = {x[DIST_W-1], x} + {y[DIST_W-1], y};
		if (s[DIST_W] != s[DIST_W-1]) begin
			return s[DIST_W] ? DIST_MIN : DIST_MAX;
		end
		return s[DIST_W-1:0];
	endfunction

endpackage

@@ hw/rtl/apsp_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module apsp_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/all_pairs_shortest_path.sv @@
`timescale 1ns / 1ps
// Top level: Floyd-Warshall distance matrix engine with command stream in, result stream out.
// Run issues one relaxation per cycle while it sweeps the columns of a row; each row
//   first fetches its leg (ST_LEG_RD, ST_LEG_WAIT), and rows whose leg is unreachable
//   skip the column pass. One item is worked on at a time.
// Reset (arst_n low, asynchronous): node_count = 16, matrix reads as unreachable
//   everywhere except a zero-distance diagonal, no result pending.
module all_pairs_shortest_path
	import apsp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: node_count
	input  logic                  cfg_we,
	input  logic [CNT_W-1:0]      cfg_wdata,
	// command stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // src_node[3:0], dst_node[7:4], edge_weight[23:8]
	input  logic [IN_USER_W-1:0]  s_tuser,   // command[1:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // distance[23:0]
	output logic [OUT_USER_W-1:0] m_tuser    // reachable[0], done_res[1]
);

	// ------------------------------------------------------------------
	// Input unpacking
	// ------------------------------------------------------------------
	apsp_cmd_t                cmd_in;
	logic [IDX_W-1:0]         src_in;
	logic [IDX_W-1:0]         dst_in;
	logic signed [WGT_W-1:0]  wgt_in;
	logic                     in_range;
	logic [ADDR_W-1:0]        in_addr;
	logic                     s_xfer;

	assign cmd_in   = apsp_cmd_t'(s_tuser);
	assign src_in   = s_tdata[IDX_W-1:0];
	assign dst_in   = s_tdata[2*IDX_W-1:IDX_W];
	assign wgt_in   = s_tdata[2*IDX_W+WGT_W-1:2*IDX_W];
	assign in_range = (CNT_W'(src_in) < NODE_LIMIT) && (CNT_W'(dst_in) < NODE_LIMIT);
	assign in_addr  = {src_in[NODE_W-1:0], dst_in[NODE_W-1:0]};
	assign s_xfer   = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] node_count_q;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_LIMIT;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// active node count, clamped to the matrix size
	assign cnt      = (node_count_q > NODE_LIMIT) ? NODE_LIMIT : node_count_q;
	assign last_idx = cnt - 1'b1;

	// ------------------------------------------------------------------
	// Sequencer state and loop counters
	// ------------------------------------------------------------------
	apsp_state_t       state_q, state_d;
	logic [NODE_W-1:0] mid_q, row_q, col_q;
	logic              last_mid, last_row, last_col;

	assign last_mid = (CNT_W'(mid_q) == last_idx);
	assign last_row = (CNT_W'(row_q) == last_idx);
	assign last_col = (CNT_W'(col_q) == last_idx);

	// ------------------------------------------------------------------
	// Matrix storage: two RAM copies with identical writes give two reads
	// per cycle. Port A reads the pivot-row leg (or the read/leg entry),
	// port B reads the target entry of the current relaxation.
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0]  rd_a_addr, rd_b_addr;
	logic [ENTRY_W-1:0] ram_a_rdata, ram_b_rdata;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	apsp_entry_t        wr_data;

	apsp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_a_addr),
		.rdata (ram_a_rdata)
	);

	apsp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_b_addr),
		.rdata (ram_b_rdata)
	);

	// Written-since-clear flags; an unwritten entry reads as its reset value
	// (reachable at zero on the diagonal, unreachable elsewhere). A clear
	// command only drops these flags.
	logic [ENTRIES-1:0] vld_q;
	logic               clr;

	// Per-port read side info captured with the address: written flag,
	// diagonal position, and a bypass for a write to the same entry in the
	// issue cycle (RAM returns old data there).
	logic        vld_a_s1, diag_a_s1, fwd_a_s1;
	logic        vld_b_s1, diag_b_s1, fwd_b_s1;
	apsp_entry_t fwd_data_s1;
	apsp_entry_t ent_a, ent_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vld_a_s1    <= vld_q[rd_a_addr];
		diag_a_s1   <= (rd_a_addr[ADDR_W-1:NODE_W] == rd_a_addr[NODE_W-1:0]);
		fwd_a_s1    <= wr_en && (wr_addr == rd_a_addr);
		vld_b_s1    <= vld_q[rd_b_addr];
		diag_b_s1   <= (rd_b_addr[ADDR_W-1:NODE_W] == rd_b_addr[NODE_W-1:0]);
		fwd_b_s1    <= wr_en && (wr_addr == rd_b_addr);
		fwd_data_s1 <= wr_data;
	end

	always_comb begin
		if (fwd_a_s1) begin
			ent_a = fwd_data_s1;
		end else if (vld_a_s1) begin
			ent_a = apsp_entry_t'(ram_a_rdata);
		end else begin
			ent_a.reach    = diag_a_s1;
			ent_a.path_len = '0;
		end
		if (fwd_b_s1) begin
			ent_b = fwd_data_s1;
		end else if (vld_b_s1) begin
			ent_b = apsp_entry_t'(ram_b_rdata);
		end else begin
			ent_b.reach    = diag_b_s1;
			ent_b.path_len = '0;
		end
	end

	// ------------------------------------------------------------------
	// Relaxation stage: one column per cycle.
	// leg_q holds dist[row][mid]; it follows the write when col == mid so
	// later columns of the row see the updated leg.
	// ------------------------------------------------------------------
	logic                     rlx_vld_s1;
	logic [ADDR_W-1:0]        rlx_addr_s1;
	logic                     col_mid_s1;
	logic signed [DIST_W-1:0] leg_q;
	logic signed [DIST_W-1:0] rlx_sum;
	logic                     rlx_we;

	assign rlx_sum = sat_add(leg_q, ent_a.path_len);
	assign rlx_we  = rlx_vld_s1 && ent_a.reach &&
		(!ent_b.reach || (rlx_sum < ent_b.path_len));

	// sequencer strobes
	logic edge_we;
	logic issue;
	logic start_run;
	logic leg_ld;
	logic adv_row;
	logic col_inc;
	logic ld_read;
	logic ld_zero;
	logic out_ld;

	// single write port: edge load when idle, relaxation write during a run
	always_comb begin
		wr_en = edge_we || rlx_we;
		if (edge_we) begin
			wr_addr          = in_addr;
			wr_data.reach    = 1'b1;
			wr_data.path_len = {{(DIST_W-WGT_W){wgt_in[WGT_W-1]}}, wgt_in};
		end else begin
			wr_addr          = rlx_addr_s1;
			wr_data.reach    = 1'b1;
			wr_data.path_len = rlx_sum;
		end
	end

	// ------------------------------------------------------------------
	// Next state and strobes
	// ------------------------------------------------------------------
	logic m_tvalid_q;

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		clr       = 1'b0;
		edge_we   = 1'b0;
		issue     = 1'b0;
		start_run = 1'b0;
		leg_ld    = 1'b0;
		adv_row   = 1'b0;
		col_inc   = 1'b0;
		ld_read   = 1'b0;
		ld_zero   = 1'b0;
		out_ld    = 1'b0;
		rd_a_addr = {mid_q, col_q};
		rd_b_addr = {row_q, col_q};

		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				rd_a_addr = in_addr;
				if (s_xfer) begin
					unique case (cmd_in)
						CMD_CLEAR: begin
							clr     = 1'b1;
							ld_zero = 1'b1;
							state_d = ST_RESP;
						end
						CMD_EDGE: begin
							edge_we = in_range;
							ld_zero = 1'b1;
							state_d = ST_RESP;
						end
						CMD_RUN: begin
							start_run = 1'b1;
							ld_zero   = 1'b1;
							state_d   = (cnt == '0) ? ST_FINISH : ST_LEG_RD;
						end
						CMD_READ: begin
							state_d = ST_RDATA;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_RDATA: begin
				ld_read = 1'b1;
				state_d = ST_RESP;
			end
			ST_LEG_RD: begin
				rd_a_addr = {row_q, mid_q};
				state_d   = ST_LEG_WAIT;
			end
			ST_LEG_WAIT: begin
				if (ent_a.reach) begin
					leg_ld  = 1'b1;
					state_d = ST_COL;
				end else begin
					adv_row = 1'b1;
					state_d = (last_row && last_mid) ? ST_FINISH : ST_LEG_RD;
				end
			end
			ST_COL: begin
				issue = 1'b1;
				if (last_col) begin
					adv_row = 1'b1;
					state_d = (last_row && last_mid) ? ST_FINISH : ST_LEG_RD;
				end else begin
					col_inc = 1'b1;
				end
			end
			ST_FINISH: begin
				// a relaxation write still in flight lands in this cycle
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rlx_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rlx_vld_s1 <= issue;
		end
	end

	// loop counters and relaxation payload
	always_ff @(posedge clk) begin
		if (start_run) begin
			mid_q <= '0;
			row_q <= '0;
		end else if (adv_row) begin
			if (last_row) begin
				row_q <= '0;
				mid_q <= mid_q + 1'b1;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
		if (leg_ld) begin
			col_q <= '0;
		end else if (col_inc) begin
			col_q <= col_q + 1'b1;
		end

		if (leg_ld) begin
			leg_q <= ent_a.path_len;
		end else if (rlx_we && col_mid_s1) begin
			leg_q <= rlx_sum;
		end

		rlx_addr_s1 <= {row_q, col_q};
		col_mid_s1  <= (col_q == mid_q);
	end

	// ------------------------------------------------------------------
	// Result staging and output register
	// ------------------------------------------------------------------
	logic                     rd_in_range_q;
	logic signed [DIST_W-1:0] res_dist_q;
	logic                     res_reach_q;
	logic signed [DIST_W-1:0] m_dist_q;
	logic                     m_reach_q;

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			rd_in_range_q <= in_range;
		end
		if (ld_zero) begin
			res_dist_q  <= '0;
			res_reach_q <= 1'b0;
		end else if (ld_read) begin
			res_reach_q <= rd_in_range_q && ent_a.reach;
			res_dist_q  <= (rd_in_range_q && ent_a.reach) ? ent_a.path_len : '0;
		end
		if (out_ld) begin
			m_dist_q  <= res_dist_q;
			m_reach_q <= res_reach_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_dist_q;
	assign m_tuser  = {1'b1, m_reach_q};

endmodule

@@ sim/tb_all_pairs_shortest_path.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the all-pairs shortest path block: directed and random command streams.
module tb_all_pairs_shortest_path;
	import apsp_pkg::*;

	typedef struct {
		apsp_cmd_t                cmd;
		logic [IDX_W-1:0]         src;
		logic [IDX_W-1:0]         dst;
		logic signed [DIST_W-1:0] distance;
		logic                     reachable;
		logic                     done;
	} cmd_outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CNT_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	// shadow copy of the matrix and the node count register
	apsp_entry_t      shadow_mat [MAX_NODES][MAX_NODES];
	logic [CNT_W-1:0] shadow_nodes;

	cmd_outcome_t outcome_queue [$];
	int           fail_count = 0;
	int           burst_left = 0;
	int           stall_mode = 0;
	int           mode_left  = 0;

	all_pairs_shortest_path dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void shadow_clear();
		for (int r = 0; r < MAX_NODES; r++) begin
			for (int c = 0; c < MAX_NODES; c++) begin
				shadow_mat[r][c].path_len = '0;
				shadow_mat[r][c].reach    = (r == c);
			end
		end
	endfunction

	// Floyd-Warshall pass; unreachable legs are skipped, sums clamp to the distance range
	function automatic void shadow_relax();
		int n;
		int leg_a;
		int leg_b;
		int total;
		int cur;
		n = (shadow_nodes > MAX_NODES) ? MAX_NODES : int'(shadow_nodes);
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < n; i++) begin
				if (!shadow_mat[i][k].reach) continue;
				for (int j = 0; j < n; j++) begin
					if (!shadow_mat[k][j].reach) continue;
					leg_a = int'(shadow_mat[i][k].path_len);
					leg_b = int'(shadow_mat[k][j].path_len);
					total = leg_a + leg_b;
					if (total > int'(DIST_MAX)) total = int'(DIST_MAX);
					if (total < int'(DIST_MIN)) total = int'(DIST_MIN);
					cur = int'(shadow_mat[i][j].path_len);
					if (!shadow_mat[i][j].reach || total < cur) begin
						shadow_mat[i][j].path_len = total[DIST_W-1:0];
						shadow_mat[i][j].reach    = 1'b1;
					end
				end
			end
		end
	endfunction

	function automatic cmd_outcome_t apply_command(apsp_cmd_t cmd, logic [IDX_W-1:0] src,
			logic [IDX_W-1:0] dst, logic signed [WGT_W-1:0] wgt);
		cmd_outcome_t r;
		r.cmd       = cmd;
		r.src       = src;
		r.dst       = dst;
		r.distance  = '0;
		r.reachable = 1'b0;
		r.done      = 1'b1;
		case (cmd)
			CMD_CLEAR: shadow_clear();
			CMD_EDGE: begin
				shadow_mat[src][dst].path_len = DIST_W'(wgt);
				shadow_mat[src][dst].reach    = 1'b1;
			end
			CMD_RUN: shadow_relax();
			default: begin
				if (shadow_mat[src][dst].reach) begin
					r.distance  = shadow_mat[src][dst].path_len;
					r.reachable = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// call at a falling edge; returns at a falling edge
	task automatic send_item(apsp_cmd_t cmd, logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst,
			logic signed [WGT_W-1:0] wgt);
		s_tdata  = {wgt, dst, src};
		s_tuser  = cmd;
		s_tvalid = 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		outcome_queue.push_back(apply_command(cmd, src, dst, wgt));
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_results();
		s_tvalid = 1'b0;
		while (outcome_queue.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register writes only while nothing is in flight
	task automatic set_node_count(logic [CNT_W-1:0] value);
		drain_results();
		cfg_wdata = value;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we       = 1'b0;
		shadow_nodes = value;
	endtask

	// receiver stall pattern: switches between four random stall modes
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(20, 120);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: m_tready = 1'b1;
			1: m_tready = 1'($urandom_range(0, 1));
			2: m_tready = ($urandom_range(0, 7) == 0);
			default: m_tready = (mode_left % 16) < 11;
		endcase
	end

	always @(posedge clk) begin
		cmd_outcome_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (outcome_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: distance %0d reachable %b done %b",
						$signed(m_tdata[DIST_W-1:0]), m_tuser[0], m_tuser[1]);
			end else begin
				want = outcome_queue.pop_front();
				if (m_tdata[DIST_W-1:0] !== want.distance || m_tuser[0] !== want.reachable ||
						m_tuser[1] !== want.done) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch %s src %0d dst %0d: exp dist %0d reach %b done %b, got dist %0d reach %b done %b",
							want.cmd.name(), want.src, want.dst, want.distance, want.reachable,
							want.done, $signed(m_tdata[DIST_W-1:0]), m_tuser[0], m_tuser[1]);
				end
			end
		end
	end

	task automatic test_reset_state();
		send_item(CMD_READ, 4'd0, 4'd15, 16'sd0);
		send_item(CMD_READ, 4'd15, 4'd15, -16'sd1);
	endtask

	task automatic test_edges_and_reads();
		send_item(CMD_EDGE, 4'd0, 4'd1, 16'sd32767);
		send_item(CMD_EDGE, 4'd1, 4'd2, -16'sd32768);
		send_item(CMD_EDGE, 4'd15, 4'd0, 16'sd100);
		send_item(CMD_EDGE, 4'd3, 4'd3, -16'sd5);   // diagonal, negative self loop
		send_item(CMD_READ, 4'd1, 4'd2, 16'sd0);
	endtask

	task automatic test_relaxation();
		set_node_count(5'd3);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'sd0);
		send_item(CMD_READ, 4'd0, 4'd2, 16'sd0);
		send_item(CMD_READ, 4'd2, 4'd0, 16'sd0);
		send_item(CMD_READ, 4'd15, 4'd1, 16'sd0);  // outside active nodes, untouched
	endtask

	task automatic test_node_count_limits();
		set_node_count(5'd0);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'sd0);
		send_item(CMD_READ, 4'd0, 4'd2, 16'sd0);
		set_node_count(5'd31);                       // clipped to the full matrix
		send_item(CMD_RUN, 4'd15, 4'd15, -16'sd1);
		send_item(CMD_READ, 4'd15, 4'd2, 16'sd0);
		send_item(CMD_READ, 4'd3, 4'd3, 16'sd0);
	endtask

	// a negative self loop doubles on every pass until it clamps at the bottom of the range
	task automatic test_negative_cycle();
		send_item(CMD_CLEAR, 4'd0, 4'd0, 16'sd0);
		set_node_count(5'd1);
		send_item(CMD_EDGE, 4'd0, 4'd0, -16'sd32768);
		repeat (9) send_item(CMD_RUN, 4'd0, 4'd0, 16'sd0);
		send_item(CMD_READ, 4'd0, 4'd0, 16'sd0);
		send_item(CMD_READ, 4'd0, 4'd1, 16'sd0);
	endtask

	function automatic logic [IDX_W-1:0] pick_node(int span);
		if ($urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, MAX_NODES - 1));
		return IDX_W'($urandom_range(0, span - 1));
	endfunction

	function automatic logic signed [WGT_W-1:0] pick_weight();
		if ($urandom_range(0, 3) == 0) return WGT_W'($urandom_range(0, 16'hffff));
		return WGT_W'(int'($urandom_range(0, 300)) - 40);
	endfunction

	// phases of an optional clear, edge loads, one run and reads, with some stray commands mixed in
	task automatic test_random_traffic();
		int sent;
		int cnt;
		int span;
		int pick;
		int n_loads;
		int n_reads;
		logic [IN_DATA_W-1:0] raw;
		sent = 0;
		while (sent < 110) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)      cnt = $urandom_range(2, 6);
			else if (pick < 8) cnt = $urandom_range(0, 31);
			else               cnt = MAX_NODES;
			set_node_count(cnt[CNT_W-1:0]);
			span = (cnt == 0) ? 1 : ((cnt > MAX_NODES) ? MAX_NODES : cnt);
			if ($urandom_range(0, 3) != 0) begin
				send_item(CMD_CLEAR, pick_node(span), pick_node(span), pick_weight());
				sent++;
			end
			n_loads = $urandom_range(1, (2 * span > 10) ? 10 : 2 * span);
			repeat (n_loads) begin
				send_item(CMD_EDGE, pick_node(span), pick_node(span), pick_weight());
				sent++;
			end
			if ($urandom_range(0, 2) == 0) begin
				raw = IN_DATA_W'($urandom_range(0, 24'hffffff));
				send_item(apsp_cmd_t'($urandom_range(0, 3)), raw[3:0], raw[7:4], raw[23:8]);
				sent++;
			end
			send_item(CMD_RUN, pick_node(span), pick_node(span), pick_weight());
			sent++;
			n_reads = $urandom_range(2, 6);
			repeat (n_reads) begin
				send_item(CMD_READ, pick_node(span), pick_node(span), pick_weight());
				sent++;
			end
		end
	endtask

	initial begin
		shadow_clear();
		shadow_nodes = 5'd16;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_state();
		test_edges_and_reads();
		test_relaxation();
		test_node_count_limits();
		test_negative_cycle();
		test_random_traffic();
		drain_results();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && outcome_queue.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
